// ===== src/bc3_pkg.sv =====
// Shared types, constants and texel helpers for the BC3 block decoder.
package bc3_pkg;

  localparam int unsigned TEXELS    = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned AIDX_LSB  = 16;
  localparam int unsigned CIDX_LSB  = 32;

  localparam logic [11:0] ALPHA_RECIP7 = 12'd2341;
  localparam logic [11:0] ALPHA_RECIP5 = 12'd3277;
  localparam int unsigned ALPHA_SHIFT  = 14;
  localparam logic [10:0] ALPHA_FULL5  = 11'd1275;
  localparam logic [10:0] COLOR_RECIP3 = 11'd1366;
  localparam int unsigned COLOR_SHIFT  = 12;

  typedef struct packed {
    logic [7:0]         a0;
    logic [7:0]         a1;
    logic [2:0]         a_idx;
    logic [15:0]        c0;
    logic [15:0]        c1;
    logic [1:0]         c_idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } bc3_sel_t;

  typedef struct packed {
    logic [10:0]        a_sum;
    logic               a_div7;
    logic [9:0]         r_sum;
    logic [9:0]         g_sum;
    logic [9:0]         b_sum;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } bc3_mix_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

// ===== src/bc3_if.sv =====
// Valid/ready channel interfaces for compressed blocks and decoded texels.
interface bc3_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_half;
  logic [63:0] color_half;
  logic [11:0] origin_x;
  logic [11:0] origin_y;

  modport source (output valid, alpha_half, color_half, origin_x, origin_y, input ready);
  modport sink   (input valid, alpha_half, color_half, origin_x, origin_y, output ready);
endinterface

interface bc3_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [31:0] argb;
  logic        last_texel;

  modport source (output valid, pixel_x, pixel_y, argb, last_texel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, argb, last_texel, output ready);
endinterface

// ===== src/bc3_blk_hold.sv =====
// Block holding register and texel counter that picks one texel per cycle while sel_ready is high.
module bc3_blk_hold (
  input  logic               clk,
  input  logic               rst_n,
  bc3_in_if.sink             in_ch,
  input  logic               sel_ready,
  output logic               sel_valid,
  output bc3_pkg::bc3_sel_t  sel
);

  logic                      blk_valid_r;
  logic [bc3_pkg::CNT_W-1:0] cnt_r;
  logic [63:0]               alpha_half_r;
  logic [63:0]               color_half_r;
  logic [11:0]               origin_x_r;
  logic [11:0]               origin_y_r;
  logic                      adv;
  logic                      at_last;
  logic                      accept;

  assign at_last     = (cnt_r == bc3_pkg::CNT_W'(bc3_pkg::TEXELS - 1));
  assign adv         = blk_valid_r && sel_ready;
  assign in_ch.ready = !blk_valid_r || (sel_ready && at_last);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (accept) begin
        blk_valid_r <= 1'b1;
        cnt_r       <= '0;
      end else if (adv) begin
        cnt_r <= cnt_r + 1'b1;
        if (at_last) begin
          blk_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alpha_half_r <= in_ch.alpha_half;
      color_half_r <= in_ch.color_half;
      origin_x_r   <= in_ch.origin_x;
      origin_y_r   <= in_ch.origin_y;
    end
  end

  assign sel_valid = blk_valid_r;

  always_comb begin
    sel.a0    = alpha_half_r[7:0];
    sel.a1    = alpha_half_r[15:8];
    sel.a_idx = alpha_half_r[bc3_pkg::AIDX_LSB + 3 * cnt_r +: 3];
    sel.c0    = color_half_r[15:0];
    sel.c1    = color_half_r[31:16];
    sel.c_idx = color_half_r[bc3_pkg::CIDX_LSB + 2 * cnt_r +: 2];
    sel.x     = origin_x_r + 12'(cnt_r[1:0]);
    sel.y     = origin_y_r + 12'(cnt_r[3:2]);
    sel.last  = at_last;
  end

endmodule

// ===== src/bc3_texel_mix.sv =====
// Weighted endpoint sums for one texel, registered ahead of the divide.
module bc3_texel_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sel_valid,
  output logic               sel_ready,
  input  bc3_pkg::bc3_sel_t  sel,
  output logic               mix_valid,
  input  logic               mix_ready,
  output bc3_pkg::bc3_mix_t  mix
);

  logic               mix_valid_r;
  bc3_pkg::bc3_mix_t  mix_r;
  bc3_pkg::bc3_mix_t  mix_nxt;
  logic [2:0]         w0;
  logic [2:0]         w1;
  logic               div7;
  logic               full5;
  logic [7:0]         c0_ch [3];
  logic [7:0]         c1_ch [3];
  logic [9:0]         c_sum [3];

  assign sel_ready = !mix_valid_r || mix_ready;

  always_comb begin
    div7  = (sel.a0 > sel.a1);
    full5 = 1'b0;
    if (div7) begin
      case (sel.a_idx)
        3'd0:    begin w0 = 3'd7; w1 = 3'd0; end
        3'd1:    begin w0 = 3'd0; w1 = 3'd7; end
        default: begin w0 = 3'd0 - sel.a_idx; w1 = sel.a_idx - 3'd1; end
      endcase
    end else begin
      case (sel.a_idx)
        3'd0:    begin w0 = 3'd5; w1 = 3'd0; end
        3'd1:    begin w0 = 3'd0; w1 = 3'd5; end
        3'd6:    begin w0 = 3'd0; w1 = 3'd0; end
        3'd7:    begin w0 = 3'd0; w1 = 3'd0; full5 = 1'b1; end
        default: begin w0 = 3'd6 - sel.a_idx; w1 = sel.a_idx - 3'd1; end
      endcase
    end
  end

  always_comb begin
    c0_ch[0] = bc3_pkg::expand5(sel.c0[15:11]);
    c0_ch[1] = bc3_pkg::expand6(sel.c0[10:5]);
    c0_ch[2] = bc3_pkg::expand5(sel.c0[4:0]);
    c1_ch[0] = bc3_pkg::expand5(sel.c1[15:11]);
    c1_ch[1] = bc3_pkg::expand6(sel.c1[10:5]);
    c1_ch[2] = bc3_pkg::expand5(sel.c1[4:0]);
    for (int c = 0; c < 3; c++) begin
      case (sel.c_idx)
        2'd0:    c_sum[c] = 10'(c0_ch[c]) + 10'({c0_ch[c], 1'b0});
        2'd1:    c_sum[c] = 10'(c1_ch[c]) + 10'({c1_ch[c], 1'b0});
        2'd2:    c_sum[c] = 10'({c0_ch[c], 1'b0}) + 10'(c1_ch[c]);
        default: c_sum[c] = 10'(c0_ch[c]) + 10'({c1_ch[c], 1'b0});
      endcase
    end
  end

  always_comb begin
    mix_nxt.a_sum  = full5 ? bc3_pkg::ALPHA_FULL5
                           : 11'(11'(w0) * 11'(sel.a0)) + 11'(11'(w1) * 11'(sel.a1));
    mix_nxt.a_div7 = div7;
    mix_nxt.r_sum  = c_sum[0];
    mix_nxt.g_sum  = c_sum[1];
    mix_nxt.b_sum  = c_sum[2];
    mix_nxt.x      = sel.x;
    mix_nxt.y      = sel.y;
    mix_nxt.last   = sel.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_valid_r <= 1'b0;
    end else if (sel_ready) begin
      mix_valid_r <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_ready && sel_valid) begin
      mix_r <= mix_nxt;
    end
  end

  assign mix_valid = mix_valid_r;
  assign mix       = mix_r;

endmodule

// ===== src/bc3_texel_out.sv =====
// Reciprocal divide of the texel sums and the result register.
module bc3_texel_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mix_valid,
  output logic               mix_ready,
  input  bc3_pkg::bc3_mix_t  mix,
  bc3_out_if.source          out_ch
);

  logic        out_valid_r;
  logic [11:0] pixel_x_r;
  logic [11:0] pixel_y_r;
  logic [31:0] argb_r;
  logic        last_r;
  logic [22:0] a_prod;
  logic [20:0] r_prod;
  logic [20:0] g_prod;
  logic [20:0] b_prod;
  logic [31:0] argb_nxt;

  assign mix_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    a_prod = 23'(mix.a_sum) *
             23'(mix.a_div7 ? bc3_pkg::ALPHA_RECIP7 : bc3_pkg::ALPHA_RECIP5);
    r_prod = 21'(mix.r_sum) * 21'(bc3_pkg::COLOR_RECIP3);
    g_prod = 21'(mix.g_sum) * 21'(bc3_pkg::COLOR_RECIP3);
    b_prod = 21'(mix.b_sum) * 21'(bc3_pkg::COLOR_RECIP3);
    argb_nxt = {a_prod[bc3_pkg::ALPHA_SHIFT +: 8], r_prod[bc3_pkg::COLOR_SHIFT +: 8],
                g_prod[bc3_pkg::COLOR_SHIFT +: 8], b_prod[bc3_pkg::COLOR_SHIFT +: 8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mix_ready) begin
      out_valid_r <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_ready && mix_valid) begin
      pixel_x_r <= mix.x;
      pixel_y_r <= mix.y;
      argb_r    <= argb_nxt;
      last_r    <= mix.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = pixel_x_r;
  assign out_ch.pixel_y    = pixel_y_r;
  assign out_ch.argb       = argb_r;
  assign out_ch.last_texel = last_r;

endmodule

// ===== src/bc3_block_decoder.sv =====
// Top level of the BC3 block decoder: block holder, texel sums, divide and result register.
//
//   channel | dir | payload                                   | handshake
//   in_ch   | in  | alpha_half, color_half, origin_x, origin_y | valid/ready
//   out_ch  | out | pixel_x, pixel_y, argb, last_texel         | valid/ready
//
// One block yields 16 texels, one per cycle while out_ch does not stall; with
// the single block holding register and its texel counter, a new block waits for the current one.
// The next block is taken in the cycle its predecessor's last texel moves on.
// A block's first texel goes through the block holding, sum and result registers to out_ch.
// Reset is synchronous on rst_n and empties all stages; a stall on out_ch holds the
// result register, and once the sum register is full it holds that and the texel counter.
module bc3_block_decoder (
  input  logic       clk,
  input  logic       rst_n,
  bc3_in_if.sink     in_ch,
  bc3_out_if.source  out_ch
);

  logic               sel_valid;
  logic               sel_ready;
  bc3_pkg::bc3_sel_t  sel;
  logic               mix_valid;
  logic               mix_ready;
  bc3_pkg::bc3_mix_t  mix;

  bc3_blk_hold u_hold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .sel_ready (sel_ready),
    .sel_valid (sel_valid),
    .sel       (sel)
  );

  bc3_texel_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel_valid (sel_valid),
    .sel_ready (sel_ready),
    .sel       (sel),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix       (mix)
  );

  bc3_texel_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix       (mix),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/bc3_checker.sv =====
// Port-level assertions for the BC3 block decoder and their bind.
module bc3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [31:0] argb,
  input logic        last_texel
);

  logic [3:0]  cnt_r;
  logic [11:0] first_x_r;
  logic [11:0] first_y_r;
  logic        out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (out_acc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && cnt_r == 4'd0) begin
      first_x_r <= pixel_x;
      first_y_r <= pixel_y;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(argb) && $stable(pixel_x) && $stable(pixel_y)
                                && $stable(last_texel))
    else $error("out payload changed while stalled");

  a_last_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (last_texel == (cnt_r == 4'd15)))
    else $error("last_texel not on the sixteenth texel");

  a_raster: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && cnt_r != 4'd0 |-> (pixel_x == first_x_r + 12'(cnt_r[1:0]))
                                 && (pixel_y == first_y_r + 12'(cnt_r[3:2])))
    else $error("texel coordinates out of raster order");

endmodule

bind bc3_block_decoder bc3_checker u_bc3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_x    (out_ch.pixel_x),
  .pixel_y    (out_ch.pixel_y),
  .argb       (out_ch.argb),
  .last_texel (out_ch.last_texel)
);
